FILE: rtl/byte_stuffed_frame_decoder_assert.svh
// Assertion macros shared by the frame decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BYTE_STUFFED_FRAME_DECODER_ASSERT_SVH
`define BYTE_STUFFED_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BSFD_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bsfd_pkg.sv
// Constants and codes for the byte-stuffed frame decoder.
// No dependencies; imported by byte_stuffed_frame_decoder, bsfd_result_checker and the test top.
package bsfd_pkg;

    localparam int DATA_W      = 8;
    localparam int CMD_W       = 16;
    localparam int OUT_DATA_W  = 24;
    localparam int REG_IDX_W   = 2;
    localparam int MAX_FRAME   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_FRAME + 1);
    localparam int MIN_FRAME   = 4;
    localparam int PAYLOAD_OFS = 4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_START_CODE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STOP_CODE   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_XOR_KEY     = 2'd3;

    // Register reset values
    localparam logic [DATA_W-1:0] START_CODE_RST  = 8'h02;
    localparam logic [DATA_W-1:0] STOP_CODE_RST   = 8'h03;
    localparam logic [DATA_W-1:0] ESCAPE_CODE_RST = 8'h10;
    localparam logic [DATA_W-1:0] XOR_KEY_RST     = 8'h20;

    // Decode modes
    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_FRAME  = 2'd1;
    localparam logic [1:0] MODE_ESCAPE = 2'd2;

    // Readout phases
    localparam logic [1:0] PH_INTAKE = 2'd0;
    localparam logic [1:0] PH_READ   = 2'd1;
    localparam logic [1:0] PH_LOAD   = 2'd2;
    localparam logic [1:0] PH_EMPTY  = 2'd3;

endpackage

FILE: rtl/byte_stuffed_frame_decoder.sv
// Byte-stuffed frame decoder: frame hunt, unstuffing, checksum and readout.
// Depends on bsfd_pkg and byte_stuffed_frame_decoder_assert.svh.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  rx_byte
// m_*       out  m_tvalid/m_tready  frame_command, payload_byte, payload_present, frame_end
// cfg_*     in   cfg_wr_en          start, stop, escape codes and xor key
//
// Intake takes one byte per cycle while no frame is being read out.
// A good stop byte starts readout of the frame store: each payload item
// takes a store read, then an output register load that waits for a free output
// register; s_tready is low until the last item of the frame sits in the output register.
// m_tready low holds the output register and the readout sequencer.
// aresetn is synchronous; the frame store itself is not cleared.
`include "byte_stuffed_frame_decoder_assert.svh"

module byte_stuffed_frame_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bsfd_pkg::DATA_W-1:0]      s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bsfd_pkg::OUT_DATA_W-1:0]  m_tdata,   // [15:0] frame_command, [23:16] payload_byte
    output logic                             m_tuser,   // [0] payload_present
    output logic                             m_tlast,   // frame_end
    input  logic                             cfg_wr_en,
    input  logic [bsfd_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [bsfd_pkg::DATA_W-1:0]      cfg_wdata
);
    import bsfd_pkg::*;

    logic [DATA_W-1:0] start_code_reg, stop_code_reg, escape_code_reg, xor_key_reg;

    logic [1:0]        mode_reg, mode_next;
    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CMD_W-1:0]  sum_reg, sum_next;
    logic              ovf_reg, ovf_next;
    logic [CMD_W-1:0]  check_reg, check_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [CNT_W-1:0]  rd_addr_reg, rd_addr_next;

    logic              out_valid_reg, out_valid_next;
    logic [CMD_W-1:0]  out_cmd_reg, out_cmd_next;
    logic [DATA_W-1:0] out_byte_reg, out_byte_next;
    logic              out_present_reg, out_present_next;
    logic              out_last_reg, out_last_next;

    logic [DATA_W-1:0] store_mem [STORE_DEPTH];
    logic [DATA_W-1:0] mem_q;
    logic              mem_we;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;

    logic              s_accept;
    logic              out_free;
    logic              store_en;
    logic [DATA_W-1:0] store_val;
    logic              is_stop;
    logic              frame_ok;
    logic              rd_last;

    assign s_tready = (phase_reg == PH_INTAKE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign is_stop  = (mode_reg == MODE_FRAME) && (s_tdata != escape_code_reg)
                      && (s_tdata == stop_code_reg);
    assign frame_ok = !ovf_reg && (count_reg >= CNT_W'(MIN_FRAME)) && (check_reg == sum_reg);
    assign rd_last  = ((rd_addr_reg + CNT_W'(1)) == count_reg);
    assign mem_re   = (phase_reg == PH_READ);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_byte_reg, out_cmd_reg};
    assign m_tuser  = out_present_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        ovf_next         = ovf_reg;
        check_next       = check_reg;
        cmd_next         = cmd_reg;
        rd_addr_next     = rd_addr_reg;
        out_valid_next   = out_valid_reg;
        out_cmd_next     = out_cmd_reg;
        out_byte_next    = out_byte_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;
        store_en         = 1'b0;
        store_val        = s_tdata;
        mem_we           = 1'b0;
        mem_wdata        = s_tdata;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (s_accept) begin
            case (mode_reg)
                MODE_FRAME: begin
                    if (s_tdata == escape_code_reg) begin
                        mode_next = MODE_ESCAPE;
                    end else if (s_tdata == stop_code_reg) begin
                        mode_next = MODE_WAIT;
                        if (frame_ok) begin
                            rd_addr_next = CNT_W'(PAYLOAD_OFS);
                            if (count_reg == CNT_W'(MIN_FRAME)) begin
                                phase_next = PH_EMPTY;
                            end else begin
                                phase_next = PH_READ;
                            end
                        end
                    end else if (s_tdata == start_code_reg) begin
                        count_next = '0;
                        sum_next   = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        store_en = 1'b1;
                    end
                end
                MODE_ESCAPE: begin
                    store_en  = 1'b1;
                    store_val = s_tdata ^ xor_key_reg;
                    mode_next = MODE_FRAME;
                end
                default: begin
                    if (s_tdata == start_code_reg) begin
                        count_next = '0;
                        sum_next   = '0;
                        ovf_next   = 1'b0;
                        mode_next  = MODE_FRAME;
                    end else begin
                        mode_next = MODE_WAIT;
                    end
                end
            endcase
        end

        if (store_en) begin
            if (count_reg < CNT_W'(MAX_FRAME)) begin
                mem_we    = 1'b1;
                mem_wdata = store_val;
                case (count_reg)
                    CNT_W'(0): check_next[7:0]  = store_val;
                    CNT_W'(1): check_next[15:8] = store_val;
                    CNT_W'(2): cmd_next[7:0]    = store_val;
                    CNT_W'(3): cmd_next[15:8]   = store_val;
                    default: ;
                endcase
                if (count_reg >= CNT_W'(2)) begin
                    sum_next = sum_reg + CMD_W'(store_val);
                end
                count_next = count_reg + CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        case (phase_reg)
            PH_READ: begin
                phase_next = PH_LOAD;
            end
            PH_LOAD: begin
                // hold the read data until the output register frees up
                if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_cmd_next     = cmd_reg;
                    out_byte_next    = mem_q;
                    out_present_next = 1'b1;
                    out_last_next    = rd_last;
                    if (rd_last) begin
                        phase_next = PH_INTAKE;
                    end else begin
                        rd_addr_next = rd_addr_reg + CNT_W'(1);
                        phase_next   = PH_READ;
                    end
                end
            end
            PH_EMPTY: begin
                if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_cmd_next     = cmd_reg;
                    out_byte_next    = '0;
                    out_present_next = 1'b0;
                    out_last_next    = 1'b1;
                    phase_next       = PH_INTAKE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg  <= START_CODE_RST;
            stop_code_reg   <= STOP_CODE_RST;
            escape_code_reg <= ESCAPE_CODE_RST;
            xor_key_reg     <= XOR_KEY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_START_CODE:  start_code_reg  <= cfg_wdata;
                REG_STOP_CODE:   stop_code_reg   <= cfg_wdata;
                REG_ESCAPE_CODE: escape_code_reg <= cfg_wdata;
                REG_XOR_KEY:     xor_key_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_WAIT;
            phase_reg     <= PH_INTAKE;
            count_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        check_reg       <= check_next;
        cmd_reg         <= cmd_next;
        rd_addr_reg     <= rd_addr_next;
        out_cmd_reg     <= out_cmd_next;
        out_byte_reg    <= out_byte_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
    end

    // Frame store: one write port for intake, one registered read port for readout
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[count_reg[ADDR_W-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q <= store_mem[rd_addr_reg[ADDR_W-1:0]];
        end
    end

    `BSFD_ASSERT_IMPLIES(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_FRAME), "byte count beyond frame limit")
    `BSFD_ASSERT_IMPLIES(a_ovf_full, aclk, aresetn, ovf_reg, count_reg == CNT_W'(MAX_FRAME), "overflow flagged with store not full")
    `BSFD_ASSERT_IMPLIES(a_read_range, aclk, aresetn, phase_reg == PH_READ, (rd_addr_reg >= CNT_W'(PAYLOAD_OFS)) && (rd_addr_reg < count_reg), "readout address outside payload")
    `BSFD_ASSERT_IMPLIES(a_readout_mode, aclk, aresetn, phase_reg != PH_INTAKE, mode_reg == MODE_WAIT, "readout while a frame is open")
    `BSFD_ASSERT_NEXT(a_good_stop, aclk, aresetn, s_accept && is_stop && frame_ok, phase_reg != PH_INTAKE, "good frame did not start readout")

endmodule

FILE: test/bsfd_result_checker.sv
// Result checker for the byte-stuffed frame decoder: watches both streams and the
// register port, predicts the decoded items and compares them in order.
// Depends on bsfd_pkg.
module bsfd_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bsfd_pkg::DATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bsfd_pkg::OUT_DATA_W-1:0] m_tdata,   // [15:0] frame_command,
                                                       // [23:16] payload_byte
    input  logic                            m_tuser,   // [0] payload_present
    input  logic                            m_tlast,   // frame_end
    input  logic                            cfg_wr_en,
    input  logic [bsfd_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [bsfd_pkg::DATA_W-1:0]     cfg_wdata,
    output int                              fail_count,
    output int                              results_pending
);
    import bsfd_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] payload;
        logic              present;
        logic              is_last;
    } frame_result_t;

    frame_result_t decoded_items[$];

    logic [DATA_W-1:0] start_code, stop_code, escape_code, xor_key;
    logic [1:0]        mode;
    logic [DATA_W-1:0] frame_bytes [STORE_DEPTH];
    int unsigned       byte_count;
    logic [15:0]       running_sum;
    logic              overflowed;
    int                mismatches;

    task automatic restart_frame();
        byte_count = 0;
        running_sum = '0;
        overflowed = 1'b0;
    endtask

    // Bytes past MAX_FRAME are not stored; they only mark the frame as bad.
    task automatic store_frame_byte(input logic [DATA_W-1:0] b);
        if (byte_count < MAX_FRAME) begin
            frame_bytes[byte_count] = b;
            if (byte_count >= 2)
                running_sum = running_sum + 16'(b);
            byte_count++;
        end else begin
            overflowed = 1'b1;
        end
    endtask

    task automatic decode_rx_byte(input logic [DATA_W-1:0] b);
        logic [CMD_W-1:0] cmd_word;
        frame_result_t    next_result;
        case (mode)
            MODE_FRAME: begin
                if (b == escape_code) begin
                    mode = MODE_ESCAPE;
                end else if (b == stop_code) begin
                    mode = MODE_WAIT;
                    if (!overflowed && byte_count >= MIN_FRAME &&
                        {frame_bytes[1], frame_bytes[0]} == running_sum) begin
                        cmd_word = {frame_bytes[3], frame_bytes[2]};
                        if (byte_count == PAYLOAD_OFS) begin
                            next_result = '{cmd_word, 8'h00, 1'b0, 1'b1};
                            decoded_items.insert(decoded_items.size(), next_result);
                        end else begin
                            for (int i = PAYLOAD_OFS; i < byte_count; i++) begin
                                next_result = '{cmd_word, frame_bytes[i], 1'b1,
                                                i == byte_count - 1};
                                decoded_items.insert(decoded_items.size(), next_result);
                            end
                        end
                    end
                end else if (b == start_code) begin
                    restart_frame();
                end else begin
                    store_frame_byte(b);
                end
            end
            MODE_ESCAPE: begin
                store_frame_byte(b ^ xor_key);
                mode = MODE_FRAME;
            end
            default: begin
                if (b == start_code) begin
                    restart_frame();
                    mode = MODE_FRAME;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        frame_result_t want;
        if (!aresetn) begin
            start_code = START_CODE_RST;
            stop_code = STOP_CODE_RST;
            escape_code = ESCAPE_CODE_RST;
            xor_key = XOR_KEY_RST;
            mode = MODE_WAIT;
            restart_frame();
            decoded_items.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_CODE:  start_code = cfg_wdata;
                    REG_STOP_CODE:   stop_code = cfg_wdata;
                    REG_ESCAPE_CODE: escape_code = cfg_wdata;
                    REG_XOR_KEY:     xor_key = cfg_wdata;
                    default: ;
                endcase
            end
            // Results are registered, so compare before this edge's byte is decoded.
            if (m_tvalid && m_tready) begin
                if (decoded_items.size() == 0) begin
                    $error("unexpected result item: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = decoded_items.pop_front();
                    if (m_tdata[15:0] !== want.command) begin
                        $error("frame_command: expected %h, got %h", want.command, m_tdata[15:0]);
                        mismatches++;
                    end
                    if (m_tdata[23:16] !== want.payload) begin
                        $error("payload_byte: expected %h, got %h", want.payload, m_tdata[23:16]);
                        mismatches++;
                    end
                    if (m_tuser !== want.present) begin
                        $error("payload_present: expected %b, got %b", want.present, m_tuser);
                        mismatches++;
                    end
                    if (m_tlast !== want.is_last) begin
                        $error("frame_end: expected %b, got %b", want.is_last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_rx_byte(s_tdata);
        end
        results_pending <= decoded_items.size();
        fail_count <= mismatches;
    end

endmodule

FILE: test/byte_stuffed_frame_decoder_test.sv
// Top of the frame decoder test: clock, reset, byte and frame stimulus, register
// phases and the verdict. Depends on bsfd_pkg, byte_stuffed_frame_decoder and
// bsfd_result_checker.
module byte_stuffed_frame_decoder_test;
    import bsfd_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 1000;
    localparam int PHASE_BYTES   = 35;

    typedef enum {FR_GOOD, FR_BADSUM, FR_SHORT, FR_LONG, FR_RESTART, FR_NOISE} frame_kind_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int results_pending;
    int bytes_sent;
    int idle_cycles;
    bit tx_calm;
    bit rx_calm;

    // Codes currently programmed, used to stuff outgoing frames.
    logic [DATA_W-1:0] start_c = START_CODE_RST;
    logic [DATA_W-1:0] stop_c  = STOP_CODE_RST;
    logic [DATA_W-1:0] esc_c   = ESCAPE_CODE_RST;
    logic [DATA_W-1:0] key_c   = XOR_KEY_RST;

    byte_stuffed_frame_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bsfd_result_checker frame_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("byte_stuffed_frame_decoder_test NOT OK");
                $finish;
            end
        end
    end

    // Result sink: random stalls per item, with calm stretches.
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if ($urandom_range(0, 19) == 0)
                rx_calm = !rx_calm;
        end
    end

    task automatic send_byte(input logic [DATA_W-1:0] value);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Hold off input until every predicted item has come out and the block is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_codes(input logic [7:0] start_v, input logic [7:0] stop_v,
                             input logic [7:0] esc_v, input logic [7:0] key_v);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_START_CODE;
        cfg_wdata <= start_v;
        @(posedge aclk);
        cfg_index <= REG_STOP_CODE;
        cfg_wdata <= stop_v;
        @(posedge aclk);
        cfg_index <= REG_ESCAPE_CODE;
        cfg_wdata <= esc_v;
        @(posedge aclk);
        cfg_index <= REG_XOR_KEY;
        cfg_wdata <= key_v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        start_c = start_v;
        stop_c = stop_v;
        esc_c = esc_v;
        key_c = key_v;
    endtask

    // Favor the code values so stuffing is exercised often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return start_c;
            1:       return stop_c;
            2:       return esc_c;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]  body[$];
        logic [7:0]  payload[$];
        logic [15:0] sum;
        logic [15:0] cmd;
        int          len;
        if ($urandom_range(0, 5) == 0)
            tx_calm = !tx_calm;
        case (kind)
            FR_NOISE: begin
                repeat ($urandom_range(1, 4)) send_byte(pick_byte());
                return;
            end
            FR_SHORT: begin
                repeat ($urandom_range(0, 3)) body.insert(body.size(), pick_byte());
            end
            default: begin
                // Abandon a partial frame; the next start byte reopens it.
                if (kind == FR_RESTART) begin
                    send_byte(start_c);
                    repeat ($urandom_range(1, 5)) send_byte(pick_byte());
                end
                if (kind == FR_LONG)
                    len = $urandom_range(61, 68);
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(9, 60);
                else
                    len = $urandom_range(0, 8);
                cmd = 16'($urandom_range(0, 16'hFFFF));
                sum = 16'(cmd[7:0]) + 16'(cmd[15:8]);
                repeat (len) begin
                    payload.insert(payload.size(), pick_byte());
                    sum = sum + 16'(payload[$]);
                end
                if (kind == FR_BADSUM)
                    sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
                body = {sum[7:0], sum[15:8], cmd[7:0], cmd[15:8]};
                body = {body, payload};
            end
        endcase
        send_byte(start_c);
        foreach (body[i]) begin
            if (body[i] == start_c || body[i] == stop_c || body[i] == esc_c) begin
                send_byte(esc_c);
                send_byte(body[i] ^ key_c);
            end else begin
                send_byte(body[i]);
            end
        end
        send_byte(stop_c);
    endtask

    initial begin
        logic [7:0] directed[$];
        int target;
        int roll;

        // Default codes: start 02, stop 03, escape 10, key 20.
        directed = {
            8'h03, 8'h10,                                // stop and escape while hunting
            8'h02, 8'h05, 8'h03,                         // short frame
            8'h02, 8'hAA,                                // start inside a frame restarts it
            8'h02, 8'hFE, 8'h01, 8'hFF, 8'hFF, 8'h03,    // no data, command FFFF
            8'h02, 8'h15, 8'h00, 8'h00, 8'h00,           // stuffed start, stop, escape
            8'h10, 8'h22, 8'h10, 8'h23, 8'h10, 8'h30, 8'h03,
            8'h02, 8'h00, 8'h00, 8'h01, 8'h00, 8'h03     // checksum mismatch
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_byte(directed[i]);

        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                settle();
                case (phase)
                    1:       set_codes(8'h00, 8'hFF, 8'h7D, 8'hFF);
                    2:       set_codes(8'hFF, 8'h00, 8'h80, 8'h00);
                    default: set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
            target = bytes_sent + PHASE_BYTES;
            if (phase == 2)
                send_frame(FR_LONG);
            while (bytes_sent < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    send_frame(FR_GOOD);
                else if (roll < 70)
                    send_frame(FR_BADSUM);
                else if (roll < 78)
                    send_frame(FR_SHORT);
                else if (roll < 81)
                    send_frame(FR_LONG);
                else if (roll < 90)
                    send_frame(FR_RESTART);
                else
                    send_frame(FR_NOISE);
            end
        end

        settle();
        if (fail_count == 0)
            $display("byte_stuffed_frame_decoder_test OK");
        else
            $display("byte_stuffed_frame_decoder_test NOT OK");
        $finish;
    end

endmodule
